// File: rtl/absm_pkg.sv
`default_nettype none

package absm_pkg;

   // Frame size default and height store geometry
   localparam int unsigned SAMPLES_PER_FRAME_DEF = 256;
   localparam int unsigned HEIGHT_DEPTH          = 256;
   localparam int unsigned IDX_W                 = 8;
   localparam int unsigned BAR_COUNT_W           = 9;

   // Field and register widths
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned SUM_W      = 20;
   localparam int unsigned FILL_W     = 4;
   localparam int unsigned GROUP_W    = 4;
   localparam int unsigned STEPS_W    = 5;
   localparam int unsigned WIN_W      = 13;
   localparam int unsigned HEIGHT_W   = 13;
   localparam int unsigned X_W        = 12;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;

   // Shared divider geometry
   localparam int unsigned DIVIDEND_W         = 22;
   localparam int unsigned DIVISOR_W          = 9;
   localparam int unsigned DIV_BITS_PER_CYCLE = 4;

   // Register limits and reset values
   localparam logic [GROUP_W-1:0] GROUP_MIN    = 4'd1;
   localparam logic [GROUP_W-1:0] GROUP_MAX    = 4'd10;
   localparam logic [STEPS_W-1:0] STEPS_MAX    = 5'd20;
   localparam logic [WIN_W-1:0]   WIN_MIN      = 13'd1;
   localparam logic [WIN_W-1:0]   WIN_MAX      = 13'd4096;
   localparam logic [GROUP_W-1:0] GROUP_RESET  = 4'd1;
   localparam logic [STEPS_W-1:0] STEPS_RESET  = 5'd10;
   localparam logic [WIN_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [WIN_W-1:0]   HEIGHT_RESET = 13'd480;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GROUP_WIDTH     = 3'd0,
      CSR_SMOOTHING_STEPS = 3'd1,
      CSR_WINDOW_WIDTH    = 3'd2,
      CSR_WINDOW_HEIGHT   = 3'd3
   } csr_index_type;

   // Bar sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_DIV_H,
      ST_DIV_W,
      ST_DIV_X,
      ST_OUT
   } absm_state_type;

endpackage

`default_nettype wire

// File: rtl/absm_div.sv
`default_nettype none

// Restoring divider, a few quotient bits per cycle.
// done pulses one cycle; quotient holds until the next start.
module absm_div #(
   parameter int unsigned DIVIDEND_W     = absm_pkg::DIVIDEND_W,
   parameter int unsigned DIVISOR_W      = absm_pkg::DIVISOR_W,
   parameter int unsigned BITS_PER_CYCLE = absm_pkg::DIV_BITS_PER_CYCLE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int unsigned NUM_CYCLES = (DIVIDEND_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int unsigned PAD_W      = NUM_CYCLES * BITS_PER_CYCLE;
   localparam int unsigned CNT_W      = $clog2(NUM_CYCLES + 1);

   logic [PAD_W-1:0]     work_ff, work_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Several shift-subtract steps per cycle
   always_comb begin
      logic [DIVISOR_W:0]   trial;
      logic [PAD_W-1:0]     w;
      logic [DIVISOR_W-1:0] r;
      w = work_ff;
      r = rem_ff;
      for (int k = 0; k < BITS_PER_CYCLE; k++) begin
         trial = {r, w[PAD_W-1]};
         w = {w[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            r = DIVISOR_W'(trial - {1'b0, dsr_ff});
            w[0] = 1'b1;
         end else begin
            r = trial[DIVISOR_W-1:0];
         end
      end
      work_in = w;
      rem_in  = r;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_CYCLES);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            done_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= PAD_W'(dividend);
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff[DIVIDEND_W-1:0];

endmodule

`default_nettype wire

// File: rtl/audio_bar_graph_smoother.sv
// Audio bar graph smoother.
// Request channel (req_valid / req_stall): one audio magnitude per transaction,
// req_frame_start marks the first sample of a frame. Every group_width samples
// complete one bar; the bar height is averaged, blended with that bar's stored
// height and saturated to the window height. Leftover samples are dropped.
// Response channel (rsp_valid / rsp_stall): one bar rectangle per completed bar.
// Config channel (csr_valid / csr_ready, csr_index, csr_data): always ready,
// write only while no transaction is in flight.
// Intake: a sample that does not complete a bar is taken with no stall. A
// sample that completes a bar holds req_stall high until its bar is done:
// the height store is read at accept, then two multiply stages and a sum step,
// three runs of the shared divider (height, bar width, bar x), and the output
// register load. The divider produces 4 quotient bits per cycle.
// The result register lets the next sample in while a bar waits on rsp_stall;
// only a further completed bar waits until the register frees.
// Reset: config returns to 1 / 10 / 640 / 480, the frame position is cleared and
// all stored bar heights read as zero at once (per-entry valid flags).
`default_nettype none

module audio_bar_graph_smoother #(
   parameter int unsigned SAMPLES_PER_FRAME = absm_pkg::SAMPLES_PER_FRAME_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [absm_pkg::SAMPLE_W-1:0]     req_sample_level,
   input  wire logic                              req_frame_start,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [absm_pkg::IDX_W-1:0]             rsp_bar_index,
   output logic [absm_pkg::X_W-1:0]               rsp_bar_x,
   output logic [absm_pkg::HEIGHT_W-1:0]          rsp_bar_y,
   output logic [absm_pkg::WIN_W-1:0]             rsp_bar_width,
   output logic [absm_pkg::HEIGHT_W-1:0]          rsp_bar_height,
   output logic                                   rsp_frame_last_bar,
   // config channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [absm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [absm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned POS_W  = $clog2(SAMPLES_PER_FRAME + 1);
   localparam int unsigned P1_W   = absm_pkg::SUM_W + absm_pkg::STEPS_W;
   localparam int unsigned P2_W   = absm_pkg::HEIGHT_W + absm_pkg::STEPS_W;
   localparam int unsigned PROD_W = P1_W + absm_pkg::WIN_W;
   localparam int unsigned DD_W   = absm_pkg::DIVIDEND_W;
   localparam int unsigned DS_W   = absm_pkg::DIVISOR_W;
   localparam int unsigned BC_W   = absm_pkg::BAR_COUNT_W;

   function automatic logic [BC_W-1:0] cap_bars(int unsigned v);
      return (v > absm_pkg::HEIGHT_DEPTH) ? BC_W'(absm_pkg::HEIGHT_DEPTH) : BC_W'(v);
   endfunction

   // Config registers
   logic [absm_pkg::GROUP_W-1:0] group_width_ff;
   logic [absm_pkg::STEPS_W-1:0] smoothing_steps_ff;
   logic [absm_pkg::WIN_W-1:0]   window_width_ff;
   logic [absm_pkg::WIN_W-1:0]   window_height_ff;

   // Frame tracking
   logic [POS_W-1:0]            pos_ff;
   logic [absm_pkg::SUM_W-1:0]  sum_ff;
   logic [absm_pkg::FILL_W-1:0] fill_ff;
   logic [BC_W-1:0]             bar_ff;

   // Bar work registers
   absm_pkg::absm_state_type    state_ff, state_in;
   logic [absm_pkg::SUM_W-1:0]  work_sum_ff;
   logic [absm_pkg::IDX_W-1:0]  work_idx_ff;
   logic [P1_W-1:0]             p1_ff;
   logic [P2_W-1:0]             p2_ff;
   logic [DD_W-1:0]             a_ff;
   logic [DD_W-1:0]             b_ff;
   logic [absm_pkg::HEIGHT_W-1:0] height_ff;
   logic [absm_pkg::WIN_W-1:0]  width_ff;
   logic [absm_pkg::X_W-1:0]    x_ff;

   // Height store
   logic [absm_pkg::HEIGHT_W-1:0] height_mem_ff [absm_pkg::HEIGHT_DEPTH];
   logic [absm_pkg::HEIGHT_DEPTH-1:0] height_vld_ff;
   logic [absm_pkg::HEIGHT_W-1:0] rd_data_ff;
   logic                          rd_vld_ff;

   // Output register
   logic                          rsp_valid_ff;
   logic [absm_pkg::IDX_W-1:0]    rsp_idx_ff;
   logic [absm_pkg::X_W-1:0]      rsp_x_ff;
   logic [absm_pkg::HEIGHT_W-1:0] rsp_y_ff;
   logic [absm_pkg::WIN_W-1:0]    rsp_width_ff;
   logic [absm_pkg::HEIGHT_W-1:0] rsp_height_ff;
   logic                          rsp_last_ff;

   // Combinational
   logic [absm_pkg::GROUP_W-1:0] g;
   logic [absm_pkg::STEPS_W-1:0] s;
   logic [absm_pkg::WIN_W-1:0]   w;
   logic [absm_pkg::WIN_W-1:0]   h;
   logic [BC_W-1:0]              bar_count;
   logic                         req_accept;
   logic [POS_W-1:0]             pos_e;
   logic [absm_pkg::SUM_W-1:0]   sum_e, sum_add;
   logic [absm_pkg::FILL_W-1:0]  fill_e, fill_add;
   logic [BC_W-1:0]              bar_e;
   logic                         take;
   logic                         complete;
   logic [absm_pkg::HEIGHT_W-1:0] prev_height;
   logic [PROD_W-1:0]            prod_a;
   logic [absm_pkg::HEIGHT_W-1:0] height_sat;
   logic                         out_free;
   logic                         div_start;
   logic [DD_W-1:0]              div_dividend;
   logic [DS_W-1:0]              div_divisor;
   logic                         div_done;
   logic [DD_W-1:0]              div_quotient;
   logic                         mem_we;

   // Clamped config
   always_comb begin
      if (group_width_ff < absm_pkg::GROUP_MIN) g = absm_pkg::GROUP_MIN;
      else if (group_width_ff > absm_pkg::GROUP_MAX) g = absm_pkg::GROUP_MAX;
      else g = group_width_ff;
      s = (smoothing_steps_ff > absm_pkg::STEPS_MAX) ? absm_pkg::STEPS_MAX : smoothing_steps_ff;
      if (window_width_ff < absm_pkg::WIN_MIN) w = absm_pkg::WIN_MIN;
      else if (window_width_ff > absm_pkg::WIN_MAX) w = absm_pkg::WIN_MAX;
      else w = window_width_ff;
      if (window_height_ff < absm_pkg::WIN_MIN) h = absm_pkg::WIN_MIN;
      else if (window_height_ff > absm_pkg::WIN_MAX) h = absm_pkg::WIN_MAX;
      else h = window_height_ff;
   end

   // Bars per frame, capped to the height store depth
   always_comb begin
      case (g)
         4'd1:    bar_count = cap_bars(SAMPLES_PER_FRAME / 1);
         4'd2:    bar_count = cap_bars(SAMPLES_PER_FRAME / 2);
         4'd3:    bar_count = cap_bars(SAMPLES_PER_FRAME / 3);
         4'd4:    bar_count = cap_bars(SAMPLES_PER_FRAME / 4);
         4'd5:    bar_count = cap_bars(SAMPLES_PER_FRAME / 5);
         4'd6:    bar_count = cap_bars(SAMPLES_PER_FRAME / 6);
         4'd7:    bar_count = cap_bars(SAMPLES_PER_FRAME / 7);
         4'd8:    bar_count = cap_bars(SAMPLES_PER_FRAME / 8);
         4'd9:    bar_count = cap_bars(SAMPLES_PER_FRAME / 9);
         default: bar_count = cap_bars(SAMPLES_PER_FRAME / 10);
      endcase
   end

   // Sample intake: frame start clears position first
   always_comb begin
      pos_e    = req_frame_start ? '0 : pos_ff;
      sum_e    = req_frame_start ? '0 : sum_ff;
      fill_e   = req_frame_start ? '0 : fill_ff;
      bar_e    = req_frame_start ? '0 : bar_ff;
      take     = (pos_e < POS_W'(SAMPLES_PER_FRAME)) && (bar_e < bar_count);
      sum_add  = sum_e + absm_pkg::SUM_W'(req_sample_level);
      fill_add = fill_e + 1'b1;
      complete = take && (fill_add >= g);
   end

   assign req_accept  = req_valid && !req_stall;
   assign prev_height = rd_vld_ff ? rd_data_ff : '0;
   assign prod_a      = PROD_W'(p1_ff) * PROD_W'(h);
   assign height_sat  = (div_quotient > DD_W'(h)) ? h : absm_pkg::HEIGHT_W'(div_quotient);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         absm_pkg::ST_IDLE:  if (req_accept && complete) state_in = absm_pkg::ST_MUL1;
         absm_pkg::ST_MUL1:  state_in = absm_pkg::ST_MUL2;
         absm_pkg::ST_MUL2:  state_in = absm_pkg::ST_SUM;
         absm_pkg::ST_SUM:   state_in = absm_pkg::ST_DIV_H;
         absm_pkg::ST_DIV_H: if (div_done) state_in = absm_pkg::ST_DIV_W;
         absm_pkg::ST_DIV_W: if (div_done) state_in = absm_pkg::ST_DIV_X;
         absm_pkg::ST_DIV_X: if (div_done) state_in = absm_pkg::ST_OUT;
         absm_pkg::ST_OUT:   if (out_free) state_in = absm_pkg::ST_IDLE;
         default:            state_in = absm_pkg::ST_IDLE;
      endcase
   end

   // State outputs: stall, divider launches, store write
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      div_dividend = a_ff + b_ff;
      div_divisor  = DS_W'(g) * DS_W'(absm_pkg::STEPS_MAX);
      mem_we       = 1'b0;
      unique case (state_ff)
         absm_pkg::ST_IDLE:  req_stall = 1'b0;
         absm_pkg::ST_SUM:   div_start = 1'b1;
         absm_pkg::ST_DIV_H: begin
            div_start    = div_done;
            div_dividend = DD_W'(w);
            div_divisor  = bar_count;
            mem_we       = div_done;
         end
         absm_pkg::ST_DIV_W: begin
            div_start    = div_done;
            div_dividend = DD_W'(work_idx_ff) * DD_W'(w);
            div_divisor  = bar_count;
         end
         default: ;
      endcase
   end

   absm_div #(
      .DIVIDEND_W     (absm_pkg::DIVIDEND_W),
      .DIVISOR_W      (absm_pkg::DIVISOR_W),
      .BITS_PER_CYCLE (absm_pkg::DIV_BITS_PER_CYCLE)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= absm_pkg::ST_IDLE;
         group_width_ff     <= absm_pkg::GROUP_RESET;
         smoothing_steps_ff <= absm_pkg::STEPS_RESET;
         window_width_ff    <= absm_pkg::WIDTH_RESET;
         window_height_ff   <= absm_pkg::HEIGHT_RESET;
         pos_ff             <= '0;
         sum_ff             <= '0;
         fill_ff            <= '0;
         bar_ff             <= '0;
         height_vld_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         // config writes
         if (csr_valid) begin
            unique case (csr_index)
               absm_pkg::CSR_GROUP_WIDTH:
                  group_width_ff <= csr_data[absm_pkg::GROUP_W-1:0];
               absm_pkg::CSR_SMOOTHING_STEPS:
                  smoothing_steps_ff <= csr_data[absm_pkg::STEPS_W-1:0];
               absm_pkg::CSR_WINDOW_WIDTH:  window_width_ff <= csr_data;
               absm_pkg::CSR_WINDOW_HEIGHT: window_height_ff <= csr_data;
               default: ;
            endcase
         end
         // frame position
         if (req_accept) begin
            pos_ff  <= take ? pos_e + 1'b1 : pos_e;
            sum_ff  <= complete ? '0 : (take ? sum_add : sum_e);
            fill_ff <= complete ? '0 : (take ? fill_add : fill_e);
            bar_ff  <= complete ? bar_e + 1'b1 : bar_e;
         end
         if (mem_we) height_vld_ff[work_idx_ff] <= 1'b1;
         // output register
         if (state_ff == absm_pkg::ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Height store: registered read at intake, write after the height divide
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= height_mem_ff[bar_e[absm_pkg::IDX_W-1:0]];
         rd_vld_ff  <= height_vld_ff[bar_e[absm_pkg::IDX_W-1:0]];
      end
      if (mem_we) height_mem_ff[work_idx_ff] <= height_sat;
   end

   // Bar datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         work_sum_ff <= sum_add;
         work_idx_ff <= bar_e[absm_pkg::IDX_W-1:0];
      end
      if (state_ff == absm_pkg::ST_MUL1) begin
         p1_ff <= P1_W'(work_sum_ff) * P1_W'(absm_pkg::STEPS_MAX - s);
         p2_ff <= P2_W'(prev_height) * P2_W'(s);
      end
      if (state_ff == absm_pkg::ST_MUL2) begin
         // sample scale is Q0.16: drop the fraction before the divide
         a_ff <= prod_a[PROD_W-1:absm_pkg::SAMPLE_W];
         b_ff <= DD_W'(p2_ff) * DD_W'(g);
      end
      if (state_ff == absm_pkg::ST_DIV_H && div_done) height_ff <= height_sat;
      if (state_ff == absm_pkg::ST_DIV_W && div_done) width_ff <= absm_pkg::WIN_W'(div_quotient);
      if (state_ff == absm_pkg::ST_DIV_X && div_done) x_ff <= div_quotient[absm_pkg::X_W-1:0];
      if (state_ff == absm_pkg::ST_OUT && out_free) begin
         rsp_idx_ff    <= work_idx_ff;
         rsp_x_ff      <= x_ff;
         rsp_y_ff      <= h - height_ff;
         rsp_width_ff  <= width_ff;
         rsp_height_ff <= height_ff;
         rsp_last_ff   <= (BC_W'(work_idx_ff) + 1'b1) == bar_count;
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bar_index      = rsp_idx_ff;
   assign rsp_bar_x          = rsp_x_ff;
   assign rsp_bar_y          = rsp_y_ff;
   assign rsp_bar_width      = rsp_width_ff;
   assign rsp_bar_height     = rsp_height_ff;
   assign rsp_frame_last_bar = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/absm_checker.sv
`default_nettype none

module absm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [absm_pkg::IDX_W-1:0]        rsp_bar_index,
   input wire logic [absm_pkg::X_W-1:0]          rsp_bar_x,
   input wire logic [absm_pkg::HEIGHT_W-1:0]     rsp_bar_y,
   input wire logic [absm_pkg::WIN_W-1:0]        rsp_bar_width,
   input wire logic [absm_pkg::HEIGHT_W-1:0]     rsp_bar_height
);

   // A stalled bar stays valid and keeps its index and height
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bar_index)
                                 && $stable(rsp_bar_height))
      else $error("stalled bar changed");

   // Top plus height never exceeds the largest window height (4096)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_bar_y} + {1'b0, rsp_bar_height}) <= 14'd4096)
      else $error("bar top and height exceed the window");

   // Left edge plus width stays within the largest window width (4096)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b0, rsp_bar_x} + {1'b0, rsp_bar_width}) <= 14'd4096)
      else $error("bar extends past the window");

   // A new bar only appears after the request side was stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("bar issued without a compute phase");

endmodule

bind audio_bar_graph_smoother absm_checker u_absm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_bar_index  (rsp_bar_index),
   .rsp_bar_x      (rsp_bar_x),
   .rsp_bar_y      (rsp_bar_y),
   .rsp_bar_width  (rsp_bar_width),
   .rsp_bar_height (rsp_bar_height)
);

`default_nettype wire
